>>> sv/pgm_raw_stream_parser_unit_defines.svh
// assertion macros shared by the parser modules
`ifndef PGM_RAW_STREAM_PARSER_UNIT_DEFINES_SVH
`define PGM_RAW_STREAM_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define PRSP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define PRSP_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PRSP_ASSERT(label, clk, rst_n, prop, msg)
`define PRSP_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

>>> sv/prsp_pkg.sv
package prsp_pkg;

    localparam int DIM_BITS = 12;
    localparam int ACC_BITS = DIM_BITS + 4;

    typedef logic [DIM_BITS-1:0] dim_t;
    typedef logic [ACC_BITS-1:0] acc_t;
    typedef logic [7:0]          byte_t;

    localparam dim_t DIM_MAX = '1;

    typedef enum logic [1:0] {
        KIND_PIXEL   = 2'd0,
        KIND_END_OK  = 2'd1,
        KIND_END_ERR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_MAGIC    = 3'd1,
        ERR_OVERFLOW = 3'd2,
        ERR_MAXVAL   = 3'd3,
        ERR_EXCESS   = 3'd4,
        ERR_SHORT    = 3'd5
    } err_t;

    typedef enum logic [7:0] {
        PH_MAGIC   = 8'b0000_0001,
        PH_LINE    = 8'b0000_0010,
        PH_COMMENT = 8'b0000_0100,
        PH_WIDTH   = 8'b0000_1000,
        PH_HEIGHT  = 8'b0001_0000,
        PH_MAXVAL  = 8'b0010_0000,
        PH_PIXELS  = 8'b0100_0000,
        PH_ERROR   = 8'b1000_0000
    } phase_t;

    localparam byte_t CH_P     = 8'h50;
    localparam byte_t CH_5     = 8'h35;
    localparam byte_t CH_2     = 8'h32;
    localparam byte_t CH_0     = 8'h30;
    localparam byte_t CH_9     = 8'h39;
    localparam byte_t CH_HASH  = 8'h23;
    localparam byte_t CH_NL    = 8'h0A;
    localparam byte_t CH_SPACE = 8'h20;

    // result queue
    localparam int RQ_DEPTH = 3;
    typedef logic [1:0] rq_ptr_t;
    typedef logic [1:0] rq_cnt_t;

    typedef struct packed {
        kind_t kind;
        byte_t pixel_value;
        dim_t  pixel_row;
        dim_t  pixel_col;
        dim_t  image_width;
        dim_t  image_height;
        err_t  error_code;
    } result_t;

    typedef struct packed {
        logic    push;
        result_t data;
    } result_push_t;

endpackage

>>> sv/prsp_in_if.sv
interface prsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

>>> sv/prsp_out_if.sv
interface prsp_out_if import prsp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    byte_t      pixel_value;
    dim_t       pixel_row;
    dim_t       pixel_col;
    dim_t       image_width;
    dim_t       image_height;
    logic [2:0] error_code;

    modport source (output valid, output result_kind, output pixel_value, output pixel_row,
                    output pixel_col, output image_width, output image_height,
                    output error_code, input ready);
    modport sink   (input valid, input result_kind, input pixel_value, input pixel_row,
                    input pixel_col, input image_width, input image_height,
                    input error_code, output ready);
endinterface

>>> sv/pgm_raw_stream_parser_unit.sv
// Binary PGM (P5) parser. Takes one file byte per clock and keeps taking one a clock while
// results flow: a byte is registered, decoded against the header state in the next cycle and
// its result, if any, lands in a three-entry result queue, so a pixel is offered on the output
// once its queue entry is written and can be taken at the following edge. Header bytes
// and comment lines give no result; every pixel byte gives one pixel transaction with row and
// column, and the end marker gives one status transaction (image valid, or the first error
// seen) after which the parser is back at reset. The input side holds off only when the result
// queue together with the byte in flight fills all three entries, which happens only when the
// consumer stalls.
module pgm_raw_stream_parser_unit import prsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    prsp_in_if.sink           byte_stream,
    prsp_out_if.source        result_stream
);

    result_push_t res;
    result_t      head;
    rq_cnt_t      level;
    logic         busy;
    logic         take;
    logic         not_empty;

    // reserve a queue slot for the byte in flight
    assign byte_stream.ready = ({1'b0, level} + {2'b00, busy}) < 3'(RQ_DEPTH);
    assign take = byte_stream.valid && byte_stream.ready;

    prsp_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .data_byte     (byte_stream.data_byte),
        .end_of_stream (byte_stream.end_of_stream),
        .busy          (busy),
        .res           (res)
    );

    prsp_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (res),
        .pop       (result_stream.ready),
        .not_empty (not_empty),
        .level     (level),
        .head      (head)
    );

    assign result_stream.valid        = not_empty;
    assign result_stream.result_kind  = head.kind;
    assign result_stream.pixel_value  = head.pixel_value;
    assign result_stream.pixel_row    = head.pixel_row;
    assign result_stream.pixel_col    = head.pixel_col;
    assign result_stream.image_width  = head.image_width;
    assign result_stream.image_height = head.image_height;
    assign result_stream.error_code   = head.error_code;

endmodule

>>> sv/prsp_core.sv
`include "pgm_raw_stream_parser_unit_defines.svh"

module prsp_core import prsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         take,
    input  byte_t        data_byte,
    input  logic         end_of_stream,
    output logic         busy,
    output result_push_t res
);

    logic   stage_valid_reg;
    byte_t  stage_byte_reg;
    logic   stage_eos_reg;

    phase_t phase_reg, phase_next;
    logic [1:0] match_reg, match_next;
    dim_t   width_reg, width_next;
    dim_t   height_reg, height_next;
    logic   frozen_reg, frozen_next;
    dim_t   row_reg, row_next;
    dim_t   col_reg, col_next;
    err_t   saved_err_reg, saved_err_next;

    dim_t   dig_src;
    acc_t   dig_acc;
    logic   dig_over;
    logic   is_digit;
    logic   frozen_eff;
    byte_t  magic_exp;
    byte_t  maxval_exp;
    err_t   end_err;
    dim_t   col_inc;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_byte_reg <= data_byte;
            stage_eos_reg  <= end_of_stream;
        end
    end

    assign busy = stage_valid_reg;

    // digit accumulation shared by width and height
    assign dig_src  = (phase_reg == PH_HEIGHT) ? height_reg : width_reg;
    assign dig_acc  = ACC_BITS'({dig_src, 3'b000}) + ACC_BITS'({dig_src, 1'b0})
                    + ACC_BITS'(stage_byte_reg[3:0]);
    assign dig_over = dig_acc > ACC_BITS'(DIM_MAX);
    assign is_digit = stage_byte_reg inside {[CH_0:CH_9]};
    // first byte of the dimension line starts a fresh number
    assign frozen_eff = (phase_reg == PH_LINE) ? 1'b0 : frozen_reg;
    assign col_inc  = col_reg + 1'b1;

    always_comb
    begin
        case (match_reg)
            2'd0:    magic_exp = CH_P;
            2'd1:    magic_exp = CH_5;
            default: magic_exp = CH_NL;
        endcase
        case (match_reg)
            2'd0:    maxval_exp = CH_2;
            2'd1:    maxval_exp = CH_5;
            2'd2:    maxval_exp = CH_5;
            default: maxval_exp = CH_NL;
        endcase
        case (phase_reg)
            PH_MAGIC:  end_err = ERR_MAGIC;
            PH_MAXVAL: end_err = ERR_MAXVAL;
            PH_PIXELS:
            begin
                if (width_reg == '0 || height_reg == '0 || row_reg == height_reg)
                    end_err = ERR_NONE;
                else
                    end_err = ERR_SHORT;
            end
            PH_ERROR:  end_err = saved_err_reg;
            default:   end_err = ERR_SHORT;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        match_next     = match_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        frozen_next    = frozen_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        saved_err_next = saved_err_reg;

        res.push              = 1'b0;
        res.data.kind         = KIND_PIXEL;
        res.data.pixel_value  = '0;
        res.data.pixel_row    = '0;
        res.data.pixel_col    = '0;
        res.data.image_width  = width_reg;
        res.data.image_height = height_reg;
        res.data.error_code   = ERR_NONE;

        if (stage_valid_reg)
        begin
            if (stage_eos_reg)
            begin
                res.push            = 1'b1;
                res.data.kind       = (end_err == ERR_NONE) ? KIND_END_OK : KIND_END_ERR;
                res.data.error_code = end_err;
                phase_next     = PH_MAGIC;
                match_next     = '0;
                width_next     = '0;
                height_next    = '0;
                frozen_next    = 1'b0;
                row_next       = '0;
                col_next       = '0;
                saved_err_next = ERR_NONE;
            end
            else
            begin
                case (phase_reg)
                    PH_MAGIC:
                    begin
                        if (stage_byte_reg != magic_exp)
                        begin
                            saved_err_next = ERR_MAGIC;
                            phase_next     = PH_ERROR;
                        end
                        else if (match_reg == 2'd2)
                        begin
                            match_next = '0;
                            phase_next = PH_LINE;
                        end
                        else
                        begin
                            match_next = match_reg + 1'b1;
                        end
                    end
                    PH_COMMENT:
                    begin
                        if (stage_byte_reg == CH_NL)
                            phase_next = PH_LINE;
                    end
                    PH_LINE, PH_WIDTH:
                    begin
                        if (phase_reg == PH_LINE && stage_byte_reg == CH_HASH)
                        begin
                            phase_next = PH_COMMENT;
                        end
                        else
                        begin
                            phase_next  = PH_WIDTH;
                            frozen_next = frozen_eff;
                            if (stage_byte_reg == CH_SPACE)
                            begin
                                phase_next  = PH_HEIGHT;
                                frozen_next = 1'b0;
                            end
                            else if (stage_byte_reg == CH_NL)
                            begin
                                phase_next = PH_MAXVAL;
                                match_next = '0;
                            end
                            else if (!frozen_eff)
                            begin
                                if (!is_digit)
                                    frozen_next = 1'b1;
                                else if (dig_over)
                                begin
                                    saved_err_next = ERR_OVERFLOW;
                                    phase_next     = PH_ERROR;
                                end
                                else
                                    width_next = dig_acc[DIM_BITS-1:0];
                            end
                        end
                    end
                    PH_HEIGHT:
                    begin
                        if (stage_byte_reg == CH_NL)
                        begin
                            phase_next = PH_MAXVAL;
                            match_next = '0;
                        end
                        else if (!frozen_reg)
                        begin
                            if (!is_digit)
                                frozen_next = 1'b1;
                            else if (dig_over)
                            begin
                                saved_err_next = ERR_OVERFLOW;
                                phase_next     = PH_ERROR;
                            end
                            else
                                height_next = dig_acc[DIM_BITS-1:0];
                        end
                    end
                    PH_MAXVAL:
                    begin
                        if (stage_byte_reg != maxval_exp)
                        begin
                            saved_err_next = ERR_MAXVAL;
                            phase_next     = PH_ERROR;
                        end
                        else if (match_reg == 2'd3)
                        begin
                            match_next = '0;
                            row_next   = '0;
                            col_next   = '0;
                            phase_next = PH_PIXELS;
                        end
                        else
                        begin
                            match_next = match_reg + 1'b1;
                        end
                    end
                    PH_PIXELS:
                    begin
                        if (width_reg == '0 || row_reg >= height_reg)
                        begin
                            saved_err_next = ERR_EXCESS;
                            phase_next     = PH_ERROR;
                        end
                        else
                        begin
                            res.push             = 1'b1;
                            res.data.pixel_value = stage_byte_reg;
                            res.data.pixel_row   = row_reg;
                            res.data.pixel_col   = col_reg;
                            if (col_inc >= width_reg)
                            begin
                                col_next = '0;
                                row_next = row_reg + 1'b1;
                            end
                            else
                            begin
                                col_next = col_inc;
                            end
                        end
                    end
                    default:
                    begin
                        // error phase: bytes swallowed until the end marker
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MAGIC;
            match_reg     <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            frozen_reg    <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            saved_err_reg <= ERR_NONE;
        end
        else
        begin
            phase_reg     <= phase_next;
            match_reg     <= match_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            frozen_reg    <= frozen_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            saved_err_reg <= saved_err_next;
        end
    end

    `PRSP_ASSERT(a_pixel_in_frame, clk, rst_n, (res.push && res.data.kind == KIND_PIXEL) |-> (res.data.pixel_row < height_reg && res.data.pixel_col < width_reg), "pixel outside the parsed frame")
    `PRSP_ASSERT(a_end_restarts, clk, rst_n, (res.push && res.data.kind != KIND_PIXEL) |=> (phase_reg == PH_MAGIC && width_reg == '0), "parser not back at the magic line after end")
    `PRSP_ASSERT(a_col_bounded, clk, rst_n, (phase_reg == PH_PIXELS && width_reg != '0) |-> (col_reg < width_reg), "column counter ran past the width")

endmodule

>>> sv/prsp_result_queue.sv
`include "pgm_raw_stream_parser_unit_defines.svh"

module prsp_result_queue import prsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  result_push_t wr,
    input  logic         pop,
    output logic         not_empty,
    output rq_cnt_t      level,
    output result_t      head
);

    result_t entry_reg [RQ_DEPTH];
    rq_ptr_t wr_ptr_reg;
    rq_ptr_t rd_ptr_reg;
    rq_cnt_t count_reg;
    logic    pop_en;

    assign pop_en    = pop && (count_reg != '0);
    assign not_empty = count_reg != '0;
    assign level     = count_reg;
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            entry_reg[wr_ptr_reg] <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr.push)
                wr_ptr_reg <= (wr_ptr_reg == rq_ptr_t'(RQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop_en)
                rd_ptr_reg <= (rd_ptr_reg == rq_ptr_t'(RQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + rq_cnt_t'(wr.push) - rq_cnt_t'(pop_en);
        end
    end

    `PRSP_NEVER(a_no_overflow, clk, rst_n, wr.push && !pop_en && count_reg == rq_cnt_t'(RQ_DEPTH), "push into a full result queue")
    `PRSP_ASSERT(a_count_bounded, clk, rst_n, count_reg <= rq_cnt_t'(RQ_DEPTH), "result queue count beyond depth")
    `PRSP_ASSERT(a_ptr_gap, clk, rst_n, (count_reg == '0 || count_reg == rq_cnt_t'(RQ_DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg), "queue pointers disagree with count")

endmodule
